@@ rtl/core/brf_pkg.sv @@
package brf_pkg;

    // Field widths fixed by the interface.
    localparam int CW = 11;
    localparam int LW = 7;
    localparam int BW = 8;

    // Capacity after reset, before clamping to the buffer depth.
    localparam logic [CW-1:0] CAP_RESET_VAL = 11'd1024;

    // Entries in the queue between the front and back ends.
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_PEEK    = 2'd2,
        OP_DISCARD = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_NO_DATA  = 2'd2,
        ST_BUSY     = 2'd3
    } status_t;

    // What the back end has to do with a queued request.
    typedef enum logic [1:0] {
        JOB_RESULT = 2'd0,
        JOB_WRITE  = 2'd1,
        JOB_BURST  = 2'd2
    } job_kind_t;

    // Classified request, without the buffer pointer.
    typedef struct packed {
        job_kind_t       kind;
        status_t         status;
        logic [BW-1:0]   data;
        logic [LW-1:0]   len;
        logic [CW-1:0]   free;
        logic [CW-1:0]   used;
    } job_info_t;

    // Result fields leaving the back end, apart from the data byte.
    typedef struct packed {
        status_t         status;
        logic            has;
        logic            last;
        logic [CW-1:0]   free;
        logic [CW-1:0]   used;
        logic            empty;
        logic            full;
    } result_t;

endpackage

@@ rtl/core/byte_ring_fifo_burst_unit.sv @@
// Byte ring FIFO with all-or-nothing bursts. A request is taken on a clock edge
// with start high and busy low; a write burst arrives one byte per request,
// while read, peek and discard each take one request. The front end classifies
// every request in the cycle it is taken and queues it; the back end turns it
// into results, which leave through its output register one per cycle while
// it has work, each marked by result_valid for exactly one cycle, and cannot be
// held off. Writes, discards and error answers give one result each; a read
// or peek of N bytes gives N results, one byte at a time from the single read
// port of the byte buffer. Requests keep being taken at one per cycle until the
// four-entry queue between the two ends fills, and busy is high while it is
// full. Writing the capacity empties the FIFO; do so only while idle.
module byte_ring_fifo_burst_unit #(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 op,
    input  logic [brf_pkg::LW-1:0]     burst_size,
    input  logic [brf_pkg::BW-1:0]     data_byte,
    input  logic                       cfg_we,
    input  logic [brf_pkg::CW-1:0]     cfg_wdata,
    output logic                       result_valid,
    output logic [1:0]                 status,
    output logic [brf_pkg::BW-1:0]     read_byte,
    output logic                       has_byte,
    output logic                       last,
    output logic [brf_pkg::CW-1:0]     free_count,
    output logic [brf_pkg::CW-1:0]     used_count,
    output logic                       is_empty,
    output logic                       is_full
);
    import brf_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int QW = $bits(job_info_t) + PW;

    logic          push;
    logic          pop;
    logic          q_empty;
    logic          q_full;
    logic [CW-1:0] cap;
    job_info_t     front_info;
    logic [PW-1:0] front_ptr;
    logic [QW-1:0] head_word;
    job_info_t     head_info;
    logic [PW-1:0] head_ptr;
    result_t       res;

    assign busy = q_full;
    assign push = start && !q_full;

    brf_front #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .op         (op),
        .burst_size (burst_size),
        .data_byte  (data_byte),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cap        (cap),
        .info       (front_info),
        .ptr        (front_ptr)
    );

    brf_queue #(
        .W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({front_info, front_ptr}),
        .pop       (pop),
        .head      (head_word),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign head_info = job_info_t'(head_word[QW-1:PW]);
    assign head_ptr  = head_word[PW-1:0];

    brf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap),
        .q_empty   (q_empty),
        .head_info (head_info),
        .head_ptr  (head_ptr),
        .pop       (pop),
        .res_valid (result_valid),
        .res       (res),
        .res_byte  (read_byte)
    );

    assign status     = res.status;
    assign has_byte   = res.has;
    assign last       = res.last;
    assign free_count = res.free;
    assign used_count = res.used;
    assign is_empty   = res.empty;
    assign is_full    = res.full;

`ifndef SYNTH
    // A result that carries a byte always reports success.
    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && has_byte) |-> (status == ST_OK))
        else $error("byte result without ok status");

    // The bytes of a read or peek come out on consecutive cycles.
    a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |=> result_valid)
        else $error("gap inside a read burst");

    // A burst that is not finished continues with another data byte.
    a_burst_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |=> has_byte)
        else $error("burst continued without a data byte");
`endif

endmodule

@@ rtl/core/brf_queue.sv @@
module brf_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] head,
    output logic         empty,
    output logic         full
);
    import brf_pkg::*;

    localparam int QAW = $clog2(QUEUE_DEPTH);

    logic [W-1:0]   entry_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == (QAW+1)'(QUEUE_DEPTH));

    // Pointer and fill count bookkeeping.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QAW+1)'(push) - (QAW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/brf_front.sv @@
module brf_front #(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic [1:0]                       op,
    input  logic [brf_pkg::LW-1:0]           burst_size,
    input  logic [brf_pkg::BW-1:0]           data_byte,
    input  logic                             cfg_we,
    input  logic [brf_pkg::CW-1:0]           cfg_wdata,
    output logic [brf_pkg::CW-1:0]           cap,
    output brf_pkg::job_info_t               info,
    output logic [$clog2(DEPTH)-1:0]         ptr
);
    import brf_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int XW = ((PW > CW) ? PW : CW) + 1;
    localparam logic [CW-1:0] CAP_RST =
        (DEPTH < int'(CAP_RESET_VAL)) ? CW'(DEPTH) : CAP_RESET_VAL;
    localparam logic [LW-1:0] BURST_CAP = LW'(MAX_BURST);

    logic [CW-1:0] cap_reg, cap_load;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] free_reg, free_next;
    logic [LW-1:0] rem_reg, rem_next;
    logic          acc_reg, acc_next;

    logic [LW-1:0] len;
    logic [CW-1:0] used;
    logic          rem_zero;
    logic          acc;
    logic [LW-1:0] rem0;
    logic [XW-1:0] cap_x;
    logic [XW-1:0] rd_sum;
    logic [PW-1:0] rd_adv;
    logic [XW-1:0] wr_inc;
    logic [PW-1:0] wr_adv;
    logic          has_len;

    assign cap = cap_reg;

    // Clamp a written capacity into one to DEPTH.
    always_comb
    begin
        priority if (cfg_wdata == '0)
        begin
            cap_load = CW'(1);
        end
        else if (int'(cfg_wdata) > DEPTH)
        begin
            cap_load = CW'(DEPTH);
        end
        else
        begin
            cap_load = cfg_wdata;
        end
    end

    // Burst length saturation, fill level and pointer wrap arithmetic.
    always_comb
    begin
        len      = (burst_size > BURST_CAP) ? BURST_CAP : burst_size;
        used     = cap_reg - free_reg;
        rem_zero = (rem_reg == '0);
        has_len  = ({{(CW-LW){1'b0}}, len} <= used);
        cap_x    = {{(XW-CW){1'b0}}, cap_reg};
        rd_sum   = {{(XW-PW){1'b0}}, rd_ptr_reg} + {{(XW-LW){1'b0}}, len};
        rd_adv   = (rd_sum >= cap_x) ? PW'(rd_sum - cap_x) : PW'(rd_sum);
        wr_inc   = {{(XW-PW){1'b0}}, wr_ptr_reg} + XW'(1);
        wr_adv   = (wr_inc >= cap_x) ? '0 : PW'(wr_inc);
    end

    // Classify the request and update the accounting.
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        free_next   = free_reg;
        rem_next    = rem_reg;
        acc_next    = acc_reg;
        acc         = 1'b0;
        rem0        = '0;
        ptr         = rd_ptr_reg;
        info.kind   = JOB_RESULT;
        info.status = ST_OK;
        info.data   = data_byte;
        info.len    = len;

        unique case (op_t'(op))
            OP_WRITE:
            begin
                if (!(rem_zero && (len == '0)))
                begin
                    acc  = rem_zero ? ({{(CW-LW){1'b0}}, len} <= free_reg) : acc_reg;
                    rem0 = rem_zero ? len : rem_reg;
                    if (acc && (free_reg != '0))
                    begin
                        info.kind   = JOB_WRITE;
                        ptr         = wr_ptr_reg;
                        wr_ptr_next = wr_adv;
                        free_next   = free_reg - CW'(1);
                    end
                    else
                    begin
                        info.status = ST_NO_SPACE;
                    end
                    rem_next = rem0 - LW'(1);
                    acc_next = acc && (rem_next != '0);
                end
            end
            OP_READ, OP_PEEK:
            begin
                priority if (!rem_zero)
                begin
                    info.status = ST_BUSY;
                end
                else if (!has_len)
                begin
                    info.status = ST_NO_DATA;
                end
                else if (len != '0)
                begin
                    info.kind = JOB_BURST;
                    if (op_t'(op) == OP_READ)
                    begin
                        rd_ptr_next = rd_adv;
                        free_next   = free_reg + {{(CW-LW){1'b0}}, len};
                    end
                end
                else
                begin
                    // A zero length request answers ok and changes nothing.
                    info.status = ST_OK;
                end
            end
            OP_DISCARD:
            begin
                priority if (!has_len)
                begin
                    info.status = ST_NO_DATA;
                end
                else if (len != '0)
                begin
                    rd_ptr_next = rd_adv;
                    free_next   = free_reg + {{(CW-LW){1'b0}}, len};
                end
                else
                begin
                    // A zero length request answers ok and changes nothing.
                    info.status = ST_OK;
                end
            end
            default:
            begin
                info.status = ST_OK;
            end
        endcase

        // Every result shows the level after the whole request.
        info.free = free_next;
        info.used = cap_reg - free_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= CAP_RST;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            free_reg   <= CAP_RST;
            rem_reg    <= '0;
            acc_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            // A capacity write restarts the buffer and cancels any burst.
            cap_reg    <= cap_load;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            free_reg   <= cap_load;
            rem_reg    <= '0;
            acc_reg    <= 1'b0;
        end
        else if (push)
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            free_reg   <= free_next;
            rem_reg    <= rem_next;
            acc_reg    <= acc_next;
        end
    end

endmodule

@@ rtl/core/brf_back.sv @@
module brf_back #(
    parameter int DEPTH = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [brf_pkg::CW-1:0]     cap,
    input  logic                       q_empty,
    input  brf_pkg::job_info_t         head_info,
    input  logic [$clog2(DEPTH)-1:0]   head_ptr,
    output logic                       pop,
    output logic                       res_valid,
    output brf_pkg::result_t           res,
    output logic [brf_pkg::BW-1:0]     res_byte
);
    import brf_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int XW = ((PW > CW) ? PW : CW) + 1;

    logic [BW-1:0] mem [DEPTH];

    logic          active_reg, active_next;
    logic [PW-1:0] bptr_reg, bptr_next;
    logic [LW-1:0] bleft_reg, bleft_next;
    job_info_t     held_reg, held_next;
    logic          out_valid_reg, out_valid_next;
    result_t       out_res_reg, out_res_next;
    logic [BW-1:0] rdata_reg;

    job_info_t     cur;
    logic [PW-1:0] cur_ptr;
    logic [LW-1:0] cur_left;
    logic          go;
    logic          wr_en;
    logic          rd_en;
    logic [XW-1:0] ptr_inc;
    logic [PW-1:0] ptr_adv;

    // Pick the running burst, or else the queue head.
    always_comb
    begin
        cur      = active_reg ? held_reg : head_info;
        cur_ptr  = active_reg ? bptr_reg : head_ptr;
        cur_left = active_reg ? bleft_reg : head_info.len;
        go       = active_reg || !q_empty;
        pop      = !active_reg && !q_empty;
        ptr_inc  = {{(XW-PW){1'b0}}, cur_ptr} + XW'(1);
        ptr_adv  = (ptr_inc >= {{(XW-CW){1'b0}}, cap}) ? '0 : PW'(ptr_inc);
    end

    // Carry out one step of the current request.
    always_comb
    begin
        active_next  = active_reg;
        bptr_next    = bptr_reg;
        bleft_next   = bleft_reg;
        held_next    = held_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        out_valid_next     = go;
        out_res_next.status = cur.status;
        out_res_next.has   = 1'b0;
        out_res_next.last  = 1'b1;
        out_res_next.free  = cur.free;
        out_res_next.used  = cur.used;
        out_res_next.empty = (cur.used == '0);
        out_res_next.full  = (cur.free == '0);

        if (go)
        begin
            unique case (cur.kind)
                JOB_WRITE:
                begin
                    wr_en = 1'b1;
                end
                JOB_BURST:
                begin
                    rd_en            = 1'b1;
                    out_res_next.has = 1'b1;
                    if (cur_left > LW'(1))
                    begin
                        out_res_next.last = 1'b0;
                        active_next       = 1'b1;
                        bptr_next         = ptr_adv;
                        bleft_next        = cur_left - LW'(1);
                        held_next         = cur;
                    end
                    else
                    begin
                        active_next = 1'b0;
                    end
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bptr_reg    <= bptr_next;
        bleft_reg   <= bleft_next;
        held_reg    <= held_next;
        out_res_reg <= out_res_next;
    end

    // Byte buffer: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cur_ptr] <= cur.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[cur_ptr];
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_res_reg;
    assign res_byte  = out_res_reg.has ? rdata_reg : '0;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import brf_pkg::*;

    localparam int RING_DEPTH = 1024;
    localparam int MAX_LEN    = 64;

    // One expected result as seen on the output ports.
    typedef struct {
        status_t        st;
        logic [BW-1:0]  rd_byte;
        logic           has;
        logic           lst;
        logic [CW-1:0]  free;
        logic [CW-1:0]  used;
        logic           empty;
        logic           full;
    } fifo_out_t;

    // Rows of the directed part: a request repeated cnt times, or a capacity write.
    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t      kind;
        op_t            op;
        logic [LW-1:0]  len;
        logic [BW-1:0]  data;
        logic [3:0]     cnt;
        logic           typed;
        status_t        st;
        logic [CW-1:0]  free;
        logic [CW-1:0]  used;
        logic [CW-1:0]  cfg_val;
    } dir_row_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           start;
    logic           busy;
    op_t            op;
    logic [LW-1:0]  burst_size;
    logic [BW-1:0]  data_byte;
    logic           cfg_we;
    logic [CW-1:0]  cfg_wdata;
    logic           result_valid;
    logic [1:0]     status;
    logic [BW-1:0]  read_byte;
    logic           has_byte;
    logic           last;
    logic [CW-1:0]  free_count;
    logic [CW-1:0]  used_count;
    logic           is_empty;
    logic           is_full;

    // Predictor state of the ring buffer.
    logic [BW-1:0]  ring_mem [0:RING_DEPTH-1];
    int             cap_now;
    int             rd_ptr;
    int             wr_ptr;
    int             free_room;
    int             burst_left;
    bit             burst_ok;

    fifo_out_t      pending_results [$];
    int             mismatch_count = 0;
    int             request_count = 0;
    bit             idle_on = 1'b1;
    dir_row_t       dir_rows [0:23];
    int             cap_plan [0:10];

    byte_ring_fifo_burst_unit #(
        .DEPTH     (RING_DEPTH),
        .MAX_BURST (MAX_LEN)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .burst_size   (burst_size),
        .data_byte    (data_byte),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .status       (status),
        .read_byte    (read_byte),
        .has_byte     (has_byte),
        .last         (last),
        .free_count   (free_count),
        .used_count   (used_count),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        if (mismatch_count <= 40)
        begin
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // Pointers advance modulo the capacity in use.
    function automatic int next_slot(int p);
        return (p + 1 >= cap_now) ? 0 : p + 1;
    endfunction

    function automatic void clear_fifo();
        rd_ptr     = 0;
        wr_ptr     = 0;
        free_room  = cap_now;
        burst_left = 0;
        burst_ok   = 1'b0;
    endfunction

    // Every result carries the fill level after the whole request.
    function automatic void push_result(status_t st, logic [BW-1:0] b, logic h, logic l);
        fifo_out_t r;
        r.st      = st;
        r.rd_byte = b;
        r.has     = h;
        r.lst     = l;
        r.free    = CW'(free_room);
        r.used    = CW'(cap_now - free_room);
        r.empty   = (cap_now == free_room);
        r.full    = (free_room == 0);
        pending_results.push_back(r);
    endfunction

    // Computes the results of one accepted request and updates the ring state.
    function automatic void apply_request(op_t o, logic [LW-1:0] sz, logic [BW-1:0] d);
        int      len;
        int      used_now;
        int      p;
        int      n;
        status_t st;
        len = (sz > MAX_LEN) ? MAX_LEN : sz;
        st  = ST_OK;
        if (o == OP_WRITE)
        begin
            // The first byte of a burst decides whether the whole burst fits.
            if (burst_left == 0)
            begin
                if (len == 0)
                begin
                    push_result(ST_OK, '0, 1'b0, 1'b1);
                    return;
                end
                burst_ok   = (len <= free_room);
                burst_left = len;
            end
            if (burst_ok && free_room > 0)
            begin
                ring_mem[wr_ptr] = d;
                wr_ptr = next_slot(wr_ptr);
                free_room--;
            end
            else
            begin
                st = ST_NO_SPACE;
            end
            burst_left--;
            if (burst_left == 0)
                burst_ok = 1'b0;
            push_result(st, '0, 1'b0, 1'b1);
            return;
        end
        if (o != OP_DISCARD && burst_left != 0)
        begin
            push_result(ST_BUSY, '0, 1'b0, 1'b1);
            return;
        end
        used_now = cap_now - free_room;
        if (used_now < len)
        begin
            push_result(ST_NO_DATA, '0, 1'b0, 1'b1);
            return;
        end
        if (len == 0)
        begin
            push_result(ST_OK, '0, 1'b0, 1'b1);
            return;
        end
        p = rd_ptr;
        for (int i = 0; i < len; i++)
            p = next_slot(p);
        if (o == OP_DISCARD)
        begin
            rd_ptr = p;
            free_room += len;
            push_result(ST_OK, '0, 1'b0, 1'b1);
            return;
        end
        // Read and peek report the counts after the whole burst on every byte.
        n = rd_ptr;
        if (o == OP_READ)
        begin
            rd_ptr = p;
            free_room += len;
        end
        for (int i = 0; i < len; i++)
        begin
            push_result(ST_OK, ring_mem[n], 1'b1, (i + 1 == len));
            n = next_slot(n);
        end
    endfunction

    // Drives one request, with an occasional gap, and waits until it is taken.
    task automatic send_req(op_t o, logic [LW-1:0] sz, logic [BW-1:0] d);
        if (idle_on && $urandom_range(99) < 18)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start      <= 1'b1;
        op         <= o;
        burst_size <= sz;
        data_byte  <= d;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        apply_request(o, sz, d);
        request_count++;
    endtask

    // Lets every outstanding result drain before returning.
    task automatic wait_idle();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (pending_results.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
    endtask

    // A capacity write clamps the value and empties the FIFO.
    task automatic write_capacity(logic [CW-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cap_now = (v == 0) ? 1 : ((v > RING_DEPTH) ? RING_DEPTH : v);
        clear_fifo();
    endtask

    // Compare each result with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        fifo_out_t want;
        if (rst_n === 1'b1 && result_valid === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result, status", status, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st)
                    report_mismatch("status", status, want.st);
                if (read_byte !== want.rd_byte)
                    report_mismatch("read_byte", read_byte, want.rd_byte);
                if (has_byte !== want.has)
                    report_mismatch("has_byte", has_byte, want.has);
                if (last !== want.lst)
                    report_mismatch("last", last, want.lst);
                if (free_count !== want.free)
                    report_mismatch("free_count", free_count, want.free);
                if (used_count !== want.used)
                    report_mismatch("used_count", used_count, want.used);
                if (is_empty !== want.empty)
                    report_mismatch("is_empty", is_empty, want.empty);
                if (is_full !== want.full)
                    report_mismatch("is_full", is_full, want.full);
            end
        end
    end

    initial
    begin
        int        k;
        int        r;
        int        len;
        int        used_now;
        int        pick;
        int        phase_start;
        op_t       o;
        logic [LW-1:0] sz;
        fifo_out_t pinned;

        start      = 1'b0;
        op         = OP_WRITE;
        burst_size = '0;
        data_byte  = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        rst_n      = 1'b0;
        cap_now    = RING_DEPTH;
        clear_fifo();

        // Directed requests: corners of every operation and the error answers.
        dir_rows = '{
            '{ROW_REQ, OP_READ,    7'd1,   8'h00, 4'd1, 1'b1, ST_NO_DATA,  11'd1024, 11'd0, 11'd0},
            '{ROW_REQ, OP_PEEK,    7'd0,   8'h00, 4'd1, 1'b1, ST_OK,       11'd1024, 11'd0, 11'd0},
            '{ROW_REQ, OP_DISCARD, 7'd0,   8'h00, 4'd1, 1'b1, ST_OK,       11'd1024, 11'd0, 11'd0},
            '{ROW_REQ, OP_WRITE,   7'd0,   8'h00, 4'd1, 1'b1, ST_OK,       11'd1024, 11'd0, 11'd0},
            '{ROW_REQ, OP_WRITE,   7'd3,   8'h00, 4'd1, 1'b1, ST_OK,       11'd1023, 11'd1, 11'd0},
            '{ROW_REQ, OP_READ,    7'd1,   8'h00, 4'd1, 1'b1, ST_BUSY,     11'd1023, 11'd1, 11'd0},
            '{ROW_REQ, OP_PEEK,    7'd2,   8'h00, 4'd1, 1'b1, ST_BUSY,     11'd1023, 11'd1, 11'd0},
            '{ROW_REQ, OP_DISCARD, 7'd1,   8'h00, 4'd1, 1'b1, ST_OK,       11'd1024, 11'd0, 11'd0},
            '{ROW_REQ, OP_WRITE,   7'd127, 8'hFF, 4'd1, 1'b1, ST_OK,       11'd1023, 11'd1, 11'd0},
            '{ROW_REQ, OP_WRITE,   7'd0,   8'hA5, 4'd1, 1'b1, ST_OK,       11'd1022, 11'd2, 11'd0},
            '{ROW_REQ, OP_PEEK,    7'd2,   8'h00, 4'd1, 1'b0, ST_OK,       11'd0,    11'd0, 11'd0},
            '{ROW_REQ, OP_READ,    7'd1,   8'h00, 4'd1, 1'b0, ST_OK,       11'd0,    11'd0, 11'd0},
            '{ROW_REQ, OP_WRITE,   7'd2,   8'h10, 4'd2, 1'b0, ST_OK,       11'd0,    11'd0, 11'd0},
            '{ROW_REQ, OP_READ,    7'd3,   8'h00, 4'd1, 1'b0, ST_OK,       11'd0,    11'd0, 11'd0},
            '{ROW_REQ, OP_READ,    7'd5,   8'h00, 4'd1, 1'b1, ST_NO_DATA,  11'd1024, 11'd0, 11'd0},
            '{ROW_CFG, OP_WRITE,   7'd0,   8'h00, 4'd0, 1'b0, ST_OK,       11'd0,    11'd0, 11'd0},
            '{ROW_REQ, OP_WRITE,   7'd1,   8'h77, 4'd1, 1'b1, ST_OK,       11'd0,    11'd1, 11'd0},
            '{ROW_REQ, OP_WRITE,   7'd1,   8'h01, 4'd1, 1'b1, ST_NO_SPACE, 11'd0,    11'd1, 11'd0},
            '{ROW_REQ, OP_WRITE,   7'd2,   8'h02, 4'd2, 1'b1, ST_NO_SPACE, 11'd0,    11'd1, 11'd0},
            '{ROW_REQ, OP_PEEK,    7'd1,   8'h00, 4'd1, 1'b0, ST_OK,       11'd0,    11'd0, 11'd0},
            '{ROW_REQ, OP_DISCARD, 7'd2,   8'h00, 4'd1, 1'b1, ST_NO_DATA,  11'd0,    11'd1, 11'd0},
            '{ROW_REQ, OP_READ,    7'd1,   8'h00, 4'd1, 1'b0, ST_OK,       11'd0,    11'd0, 11'd0},
            '{ROW_CFG, OP_WRITE,   7'd0,   8'h00, 4'd0, 1'b0, ST_OK,       11'd0,    11'd0, 11'd2047},
            '{ROW_REQ, OP_DISCARD, 7'd1,   8'h00, 4'd1, 1'b1, ST_NO_DATA,  11'd1024, 11'd0, 11'd0}
        };
        cap_plan = '{2, 3, 1, 5, 17, 64, 1024, 65, 0, 2047, 0};
        cap_plan[8]  = $urandom_range(1, 1024);
        cap_plan[10] = $urandom_range(1025, 2047);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; typed rows replace the predicted level.
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                wait_idle();
                write_capacity(dir_rows[i].cfg_val);
            end
            else
            begin
                for (k = 0; k < dir_rows[i].cnt; k++)
                begin
                    send_req(dir_rows[i].op, dir_rows[i].len, BW'(dir_rows[i].data + k));
                    if (dir_rows[i].typed)
                    begin
                        pinned         = pending_results[pending_results.size() - 1];
                        pinned.st      = dir_rows[i].st;
                        pinned.rd_byte = '0;
                        pinned.has     = 1'b0;
                        pinned.lst     = 1'b1;
                        pinned.free    = dir_rows[i].free;
                        pinned.used    = dir_rows[i].used;
                        pinned.empty   = (dir_rows[i].used == 0);
                        pinned.full    = (dir_rows[i].free == 0);
                        pending_results[pending_results.size() - 1] = pinned;
                    end
                end
            end
        end

        // Random phases, one per capacity setting; one phase runs without gaps.
        foreach (cap_plan[ph])
        begin
            wait_idle();
            write_capacity(CW'(cap_plan[ph]));
            idle_on = (ph != 6);
            phase_start = request_count;
            while (request_count - phase_start < 36)
            begin
                pick = $urandom_range(99);
                used_now = cap_now - free_room;
                if (pick < 50)
                begin
                    // Well-formed write burst, with stray requests between its bytes.
                    if ($urandom_range(1) == 1)
                    begin
                        len = $urandom_range(1, (free_room > MAX_LEN) ? MAX_LEN :
                                                ((free_room < 1) ? 1 : free_room));
                    end
                    else
                    begin
                        r = $urandom_range(99);
                        len = (r < 40) ? $urandom_range(1, 8) :
                              (r < 70) ? $urandom_range(9, 32) :
                              (r < 90) ? $urandom_range(33, MAX_LEN) : 0;
                    end
                    sz = LW'(len);
                    if (len == MAX_LEN && $urandom_range(1) == 1)
                        sz = LW'($urandom_range(MAX_LEN + 1, 127));
                    send_req(OP_WRITE, sz, BW'($urandom_range(255)));
                    for (k = 1; k < len; k++)
                    begin
                        if ($urandom_range(99) < 8)
                            send_req(op_t'($urandom_range(1, 3)), LW'($urandom_range(4)),
                                     BW'($urandom_range(255)));
                        send_req(OP_WRITE, LW'($urandom_range(127)),
                                 BW'($urandom_range(255)));
                    end
                end
                else if (pick < 88)
                begin
                    // Read, peek or discard, mostly sized to what is held.
                    o = op_t'($urandom_range(1, 3));
                    if (used_now >= MAX_LEN && $urandom_range(3) == 0)
                        sz = LW'($urandom_range(MAX_LEN, 127));
                    else if ($urandom_range(9) < 7)
                        sz = LW'($urandom_range(0, (used_now > MAX_LEN) ? MAX_LEN : used_now));
                    else
                        sz = LW'($urandom_range(127));
                    send_req(o, sz, BW'($urandom_range(255)));
                end
                else
                begin
                    // Noise: any request, which may leave a write burst open.
                    send_req(op_t'($urandom_range(3)), LW'($urandom_range(127)),
                             BW'($urandom_range(255)));
                end
            end
        end

        wait_idle();
        if (pending_results.size() != 0)
            report_mismatch("results never delivered, count", 0, pending_results.size());
        if (mismatch_count == 0)
            $display("byte_ring_fifo_burst_unit test passed");
        else
            $display("byte_ring_fifo_burst_unit test failed");
        $finish;
    end

    // Hard limit on the run time.
    initial
    begin
        #2000000;
        $display("byte_ring_fifo_burst_unit test failed");
        $finish;
    end

endmodule
